// File: hdl/hpe_pkg.sv
// Package for the Horner polynomial evaluator.
// Holds the pipeline lane type and the fixed widths and limits shared by all modules.
// No dependencies.
`default_nettype none

package hpe_pkg;

   // register file: eight coefficient registers, index port wide enough to see stray writes
   localparam int NUM_REGS       = 8;
   localparam int REG_INDEX_BITS = $clog2(NUM_REGS);
   localparam int CSR_INDEX_BITS = 4;

   // data widths
   localparam int DATA_BITS   = 32;
   localparam int SCALED_BITS = 35;   // k * coeff_k, k up to 7
   localparam int PROD_BITS   = 64;
   localparam int WIDE_BITS   = 66;

   // saturation limits in the wide sum domain
   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = -66'sd2147483648;
   localparam logic signed [DATA_BITS-1:0] DATA_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_BITS-1:0] DATA_MIN = 32'sh80000000;

   // one sample in flight: both Horner accumulators plus sticky saturation flags
   typedef struct packed {
      logic                        valid;
      logic signed [DATA_BITS-1:0] x;
      logic signed [DATA_BITS-1:0] value;
      logic signed [DATA_BITS-1:0] slope;
      logic                        value_sat;
      logic                        slope_sat;
   } hpe_lane_type;

endpackage

`default_nettype wire

// File: hdl/horner_polynomial_evaluator.sv
// Top level of the Horner polynomial evaluator: value and first derivative per sample.
// Depends on hpe_pkg, hpe_csr and hpe_stage.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ----------------------------
//  request   start, busy, req_x                      beat when start && !busy
//  response  rsp_valid, rsp_value, rsp_slope,        one-cycle strobe, no backpressure
//            rsp_value_saturated, rsp_slope_saturated
//  csr       csr_valid, csr_ready, csr_index,        beat when csr_valid && csr_ready
//            csr_data
//
// One sample is taken every cycle while busy is low. The path is one input register,
// then two registers per Horner step (32x32 multiply, then round/add/saturate), for
// NUM_COEFFS-1 steps. Reset (synchronous) clears all pipeline valid bits and the
// coefficients to zero; busy is high only while reset is held. The response side
// cannot stall, so the pipeline never holds.
`default_nettype none

module horner_polynomial_evaluator
   import hpe_pkg::*;
#(
   parameter int NUM_COEFFS = 8,
   parameter int FRAC_BITS  = 16
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [DATA_BITS-1:0]   req_x,
   // response
   output logic                               rsp_valid,
   output logic signed [DATA_BITS-1:0]        rsp_value,
   output logic signed [DATA_BITS-1:0]        rsp_slope,
   output logic                               rsp_value_saturated,
   output logic                               rsp_slope_saturated,
   // configuration
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [DATA_BITS-1:0]          csr_data
);

   localparam int LATENCY = 2 * NUM_COEFFS - 1;
   localparam int TOP     = NUM_COEFFS - 1;

   logic signed [DATA_BITS-1:0]   coeff  [NUM_REGS];
   logic signed [SCALED_BITS-1:0] scaled [NUM_REGS];
   logic                          in_accept;

   hpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coeff     (coeff),
      .scaled    (scaled)
   );

   assign busy      = reset;
   assign in_accept = start && !busy;

   // input register: seed both chains with the leading coefficient
   hpe_lane_type lanes [NUM_COEFFS];
   hpe_lane_type lane0_in;
   hpe_lane_type lane0_ff;

   always_comb begin
      lane0_in.valid     = in_accept;
      lane0_in.x         = req_x;
      lane0_in.value     = coeff[TOP];
      lane0_in.value_sat = 1'b0;
      // (N-1) * coeff_{N-1}, saturated; counts as a slope step
      if (scaled[TOP] > SCALED_BITS'(DATA_MAX)) begin
         lane0_in.slope     = DATA_MAX;
         lane0_in.slope_sat = 1'b1;
      end else if (scaled[TOP] < SCALED_BITS'(DATA_MIN)) begin
         lane0_in.slope     = DATA_MIN;
         lane0_in.slope_sat = 1'b1;
      end else begin
         lane0_in.slope     = scaled[TOP][DATA_BITS-1:0];
         lane0_in.slope_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane0_ff <= '0;
      end else begin
         lane0_ff <= lane0_in;
      end
   end

   assign lanes[0] = lane0_ff;

   // Horner steps, highest coefficient first
   for (genvar s = 1; s < NUM_COEFFS; s++) begin : g_step
      hpe_stage #(
         .FRAC_BITS (FRAC_BITS),
         .SLOPE_ON  (s <= NUM_COEFFS - 2)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .lane_i      (lanes[s-1]),
         .coeff_value (coeff[TOP-s]),
         .coeff_slope (scaled[TOP-s]),
         .lane_o      (lanes[s])
      );
   end

   // response straight from the last step register
   assign rsp_valid           = lanes[TOP].valid;
   assign rsp_value           = lanes[TOP].value;
   assign rsp_slope           = lanes[TOP].slope;
   assign rsp_value_saturated = lanes[TOP].value_sat;
   assign rsp_slope_saturated = lanes[TOP].slope_sat;

`ifndef SYNTHESIS
   // every response beat traces back to a request beat exactly one latency earlier
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_accept, LATENCY))
      else $error("response beat without matching request beat");

   // a linear polynomial's slope is coeff_1 itself and can never saturate
   a_linear_slope_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (NUM_COEFFS == 2)) |-> !rsp_slope_saturated)
      else $error("slope saturated on a linear polynomial");
`endif

endmodule

`default_nettype wire

// File: hdl/hpe_csr.sv
// Coefficient register file for the Horner polynomial evaluator.
// Also forms the derivative coefficients k * coeff_k. Depends on hpe_pkg.
`default_nettype none

module hpe_csr
   import hpe_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [DATA_BITS-1:0]           csr_data,
   output logic signed [DATA_BITS-1:0]         coeff   [NUM_REGS],
   output logic signed [SCALED_BITS-1:0]       scaled  [NUM_REGS]
);

   logic signed [DATA_BITS-1:0] coeff_ff [NUM_REGS];
   logic                        write_hit;

   // writes are always taken; indexes past the last register are dropped
   assign csr_ready = 1'b1;
   assign write_hit = csr_valid && (csr_index < CSR_INDEX_BITS'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (write_hit) begin
         coeff_ff[csr_index[REG_INDEX_BITS-1:0]] <= signed'(csr_data);
      end
   end

   // derivative coefficients, exact in 35 bits (multiply by a small constant)
   for (genvar k = 0; k < NUM_REGS; k++) begin : g_scale
      assign coeff[k]  = coeff_ff[k];
      assign scaled[k] = SCALED_BITS'(coeff_ff[k]) * SCALED_BITS'(k);
   end

endmodule

`default_nettype wire

// File: hdl/hpe_stage.sv
// One Horner step for both chains: multiply stage, then round, add and saturate stage.
// Two register stages per step. Depends on hpe_pkg.
`default_nettype none

module hpe_stage
   import hpe_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter bit SLOPE_ON  = 1'b1
)
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hpe_lane_type                   lane_i,
   input  wire logic signed [DATA_BITS-1:0]    coeff_value,
   input  wire logic signed [SCALED_BITS-1:0]  coeff_slope,
   output hpe_lane_type                        lane_o
);

   // round half up: 2^(FRAC_BITS-1), zero when there are no fraction bits
   localparam logic signed [WIDE_BITS-1:0] HALF = (66'sd1 <<< FRAC_BITS) >>> 1;

   // round the product, add the coefficient, saturate to 32 bits; {flag, value}
   function automatic logic [DATA_BITS:0] round_add_sat(
      input logic signed [PROD_BITS-1:0]   prod,
      input logic signed [SCALED_BITS-1:0] addend
   );
      logic signed [WIDE_BITS-1:0] wide;
      wide = ((WIDE_BITS'(prod) + HALF) >>> FRAC_BITS) + WIDE_BITS'(addend);
      if (wide > WIDE_MAX) begin
         return {1'b1, DATA_MAX};
      end else if (wide < WIDE_MIN) begin
         return {1'b1, DATA_MIN};
      end
      return {1'b0, wide[DATA_BITS-1:0]};
   endfunction

   // multiply stage
   logic                        valid_a_ff;
   logic signed [DATA_BITS-1:0] x_a_ff;
   logic signed [PROD_BITS-1:0] vprod_a_ff;
   logic signed [PROD_BITS-1:0] sprod_a_ff;
   logic signed [DATA_BITS-1:0] slope_a_ff;
   logic                        vsat_a_ff;
   logic                        ssat_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= lane_i.valid;
      end
      x_a_ff     <= lane_i.x;
      vprod_a_ff <= PROD_BITS'(lane_i.value) * PROD_BITS'(lane_i.x);
      sprod_a_ff <= PROD_BITS'(lane_i.slope) * PROD_BITS'(lane_i.x);
      slope_a_ff <= lane_i.slope;
      vsat_a_ff  <= lane_i.value_sat;
      ssat_a_ff  <= lane_i.slope_sat;
   end

   // round / add / saturate stage
   logic [DATA_BITS:0] vres;
   logic [DATA_BITS:0] sres;
   hpe_lane_type       lane_in;
   hpe_lane_type       lane_ff;

   always_comb begin
      vres                = round_add_sat(vprod_a_ff, SCALED_BITS'(coeff_value));
      sres                = round_add_sat(sprod_a_ff, coeff_slope);
      lane_in.valid       = valid_a_ff;
      lane_in.x           = x_a_ff;
      lane_in.value       = signed'(vres[DATA_BITS-1:0]);
      lane_in.value_sat   = vsat_a_ff | vres[DATA_BITS];
      // past the last slope step the derivative just rides along
      if (SLOPE_ON) begin
         lane_in.slope     = signed'(sres[DATA_BITS-1:0]);
         lane_in.slope_sat = ssat_a_ff | sres[DATA_BITS];
      end else begin
         lane_in.slope     = slope_a_ff;
         lane_in.slope_sat = ssat_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

`default_nettype wire

// File: sim/horner_polynomial_evaluator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for horner_polynomial_evaluator: value and slope of a degree-7 polynomial.
// Depends on hpe_pkg and the RTL under hdl/; an in-bench Horner predictor checks every result.

module horner_polynomial_evaluator_tb;
   import hpe_pkg::*;

   localparam int NUM_COEFFS   = 8;
   localparam int FRAC_BITS    = 16;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 2 * NUM_COEFFS + 8;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_PHASES    = 12;
   localparam int RANDOM_PER_PHASE = 160;
   localparam int MAX_REPORTS      = 100;

   // csr map: coefficient k at index k, the rest of the index space is unmapped
   localparam int COEFF_1_INDEX     = 1;
   localparam int FIRST_STRAY_INDEX = NUM_REGS;
   localparam int LAST_CSR_INDEX    = (1 << CSR_INDEX_BITS) - 1;

   localparam logic signed [DATA_BITS-1:0] Q_ONE  = 32'sh0001_0000;
   localparam logic signed [DATA_BITS-1:0] Q_HALF = 32'sh0000_8000;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef enum logic {BEAT_SAMPLE, BEAT_CSR} beat_kind_type;
   typedef enum int {MIX_MODERATE, MIX_LOW_DEGREE, MIX_FULL, MIX_EXTREME, MIX_BLEND}
      coeff_mix_type;

   typedef struct packed {
      beat_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [DATA_BITS-1:0]      data;
   } beat_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] x;
      logic signed [DATA_BITS-1:0] value;
      logic signed [DATA_BITS-1:0] slope;
      logic                        value_sat;
      logic                        slope_sat;
   } poly_eval_type;

   // dut inputs, all known from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [DATA_BITS-1:0]   req_x = '0;
   logic                          rsp_valid;
   logic signed [DATA_BITS-1:0]   rsp_value;
   logic signed [DATA_BITS-1:0]   rsp_slope;
   logic                          rsp_value_saturated;
   logic                          rsp_slope_saturated;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [DATA_BITS-1:0]          csr_data = '0;

   // bench state
   beat_type                    queued_beats[$];
   poly_eval_type               predicted_evals[$];
   logic signed [DATA_BITS-1:0] coeff_copy[NUM_REGS];
   int  in_flight;
   int  idle_gap;
   bit  no_idle_stretch;
   int  samples_queued;
   int  samples_accepted;
   int  coeff_writes;
   int  stray_writes;
   int  results_checked;
   int  value_sat_seen;
   int  slope_sat_seen;
   int  fail_count;
   int  cycle_count;

   horner_polynomial_evaluator #(
      .NUM_COEFFS (NUM_COEFFS),
      .FRAC_BITS  (FRAC_BITS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_x               (req_x),
      .rsp_valid           (rsp_valid),
      .rsp_value           (rsp_value),
      .rsp_slope           (rsp_slope),
      .rsp_value_saturated (rsp_value_saturated),
      .rsp_slope_saturated (rsp_slope_saturated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // clamp to 32 bits; bit 32 of the return flags a clamp
   function automatic logic [DATA_BITS:0] clamp_q(longint v);
      if (v > Q_MAX) return {1'b1, DATA_MAX};
      if (v < Q_MIN) return {1'b1, DATA_MIN};
      return {1'b0, v[DATA_BITS-1:0]};
   endfunction

   // exact product, round half up, floor shift
   function automatic longint mul_round(longint a, longint b);
      longint half;
      half = (longint'(1) << FRAC_BITS) >> 1;
      return (a * b + half) >>> FRAC_BITS;
   endfunction

   // value and derivative by Horner's rule, saturating after every step
   function automatic poly_eval_type eval_horner(logic signed [DATA_BITS-1:0] x);
      poly_eval_type       r;
      longint              xv;
      longint              acc;
      longint              d;
      logic [DATA_BITS:0]  s;
      int                  k;
      xv = longint'(x);
      r.x = x;
      r.value_sat = 1'b0;
      r.slope_sat = 1'b0;

      acc = longint'(coeff_copy[NUM_COEFFS-1]);
      for (k = NUM_COEFFS - 2; k >= 0; k--) begin
         s = clamp_q(mul_round(acc, xv) + longint'(coeff_copy[k]));
         acc = longint'($signed(s[DATA_BITS-1:0]));
         r.value_sat |= s[DATA_BITS];
      end

      // leading term of the derivative clamps on its own
      s = clamp_q(longint'(NUM_COEFFS - 1) * longint'(coeff_copy[NUM_COEFFS-1]));
      d = longint'($signed(s[DATA_BITS-1:0]));
      r.slope_sat |= s[DATA_BITS];
      for (k = NUM_COEFFS - 2; k >= 1; k--) begin
         s = clamp_q(mul_round(d, xv) + longint'(k) * longint'(coeff_copy[k]));
         d = longint'($signed(s[DATA_BITS-1:0]));
         r.slope_sat |= s[DATA_BITS];
      end

      r.value = acc[DATA_BITS-1:0];
      r.slope = d[DATA_BITS-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void queue_sample(logic [DATA_BITS-1:0] x);
      beat_type b;
      b.kind  = BEAT_SAMPLE;
      b.index = '0;
      b.data  = x;
      queued_beats = {queued_beats, b};
      samples_queued++;
   endfunction

   function automatic void queue_csr(int index, logic [DATA_BITS-1:0] data);
      beat_type b;
      b.kind  = BEAT_CSR;
      b.index = index[CSR_INDEX_BITS-1:0];
      b.data  = data;
      queued_beats = {queued_beats, b};
   endfunction

   function automatic void queue_all_coeffs(logic [DATA_BITS-1:0] data);
      int k;
      for (k = 0; k < NUM_REGS; k++)
         queue_csr(k, data);
   endfunction

   // sample point: mostly near the origin so results stay in range
   function automatic logic [DATA_BITS-1:0] pick_x();
      int unsigned r;
      int          v;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         v = int'($urandom_range(0, 6 * Q_ONE)) - 3 * Q_ONE;
         return v;
      end
      if (r < 65) begin
         v = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
         return v;
      end
      if (r < 88)
         return $urandom();
      case ($urandom_range(0, 8))
         0:       return '0;
         1:       return 32'sd1;
         2:       return -32'sd1;
         3:       return Q_HALF;
         4:       return -Q_HALF;
         5:       return Q_ONE;
         6:       return -Q_ONE;
         7:       return DATA_MAX;
         default: return DATA_MIN;
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return '0;
         3:       return 32'sd1;
         4:       return -32'sd1;
         default: return Q_ONE;
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] pick_coeff(coeff_mix_type mix, int k, int degree);
      int v;
      case (mix)
         MIX_MODERATE: begin
            v = int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
            return v;
         end
         MIX_LOW_DEGREE: begin
            if (k > degree) return '0;
            v = int'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
            return v;
         end
         MIX_FULL:    return $urandom();
         MIX_EXTREME: return pick_extreme();
         default:     return pick_coeff(coeff_mix_type'($urandom_range(0, 3)), k, degree);
      endcase
   endfunction

   // idle cycles before the next beat: mostly none or short, a few long, some bursts
   function automatic int draw_idle_gap();
      int unsigned r;
      if (no_idle_stretch) begin
         if ($urandom_range(0, 99) < 4) no_idle_stretch = 1'b0;
         return 0;
      end
      if ($urandom_range(0, 99) < 2) no_idle_stretch = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- driver

   // presents one beat at a time; a csr beat waits until the pipeline is empty
   always @(posedge clock) begin : drive_beats
      beat_type                    head;
      logic                        next_start;
      logic                        next_csr_valid;
      logic signed [DATA_BITS-1:0] next_x;
      logic [CSR_INDEX_BITS-1:0]   next_index;
      logic [DATA_BITS-1:0]        next_data;
      int                          k;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         in_flight = 0;
         idle_gap  = 0;
         for (k = 0; k < NUM_REGS; k++)
            coeff_copy[k] = '0;
      end else begin
         next_start     = start;
         next_csr_valid = csr_valid;
         next_x         = req_x;
         next_index     = csr_index;
         next_data      = csr_data;

         // retire beats taken at this edge
         if (start && !busy) begin
            predicted_evals = {predicted_evals, eval_horner(req_x)};
            samples_accepted++;
            in_flight++;
         end
         if (rsp_valid)
            in_flight--;
         if (csr_valid && csr_ready) begin
            if (csr_index < NUM_REGS) begin
               coeff_copy[csr_index[REG_INDEX_BITS-1:0]] = csr_data;
               coeff_writes++;
            end else begin
               stray_writes++;
            end
         end

         // launch the next beat once nothing is held
         if (!((start && busy) || (csr_valid && !csr_ready))) begin
            next_start     = 1'b0;
            next_csr_valid = 1'b0;
            if (idle_gap > 0) begin
               idle_gap--;
            end else if (queued_beats.size() > 0) begin
               head = queued_beats[0];
               if (head.kind == BEAT_SAMPLE) begin
                  next_start = 1'b1;
                  next_x     = head.data;
                  queued_beats.delete(0);
                  idle_gap = draw_idle_gap();
               end else if (in_flight == 0) begin
                  next_csr_valid = 1'b1;
                  next_index     = head.index;
                  next_data      = head.data;
                  queued_beats.delete(0);
                  idle_gap = draw_idle_gap();
               end
            end
         end

         start     <= next_start;
         req_x     <= next_x;
         csr_valid <= next_csr_valid;
         csr_index <= next_index;
         csr_data  <= next_data;
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void note_mismatch(string field, logic signed [DATA_BITS-1:0] x,
                                         logic [DATA_BITS-1:0] want, logic [DATA_BITS-1:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch at x=%h, expected %h, actual %h",
                  $time, field, x, want, got);
   endfunction

   always @(posedge clock) begin : check_results
      poly_eval_type want;
      if (!reset && rsp_valid) begin
         if (predicted_evals.size() == 0) begin
            fail_count++;
            $display("%0t ns: result with none predicted, value %h slope %h",
                     $time, rsp_value, rsp_slope);
         end else begin
            want = predicted_evals.pop_front();
            results_checked++;
            if (rsp_value !== want.value)
               note_mismatch("value", want.x, want.value, rsp_value);
            if (rsp_slope !== want.slope)
               note_mismatch("slope", want.x, want.slope, rsp_slope);
            if (rsp_value_saturated !== want.value_sat)
               note_mismatch("value_saturated", want.x, want.value_sat, rsp_value_saturated);
            if (rsp_slope_saturated !== want.slope_sat)
               note_mismatch("slope_saturated", want.x, want.slope_sat, rsp_slope_saturated);
            if (want.value_sat) value_sat_seen++;
            if (want.slope_sat) slope_sat_seen++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t ns: timed out with %0d samples accepted, %0d results pending",
                  $time, samples_accepted, predicted_evals.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : run_test
      int            phase;
      int            j;
      int            rot;
      int            degree;
      coeff_mix_type mix;

      // coefficients still at reset: everything evaluates to zero
      queue_sample('0);
      queue_sample(DATA_MAX);
      queue_sample(DATA_MIN);

      // all coefficients 1.0
      queue_all_coeffs(Q_ONE);
      queue_sample('0);
      queue_sample(Q_ONE);
      queue_sample(-Q_ONE);
      queue_sample(Q_HALF);

      // lone lsb in coeff_1 shows round half up on both signs; unmapped
      // indexes must leave the coefficients alone
      queue_all_coeffs('0);
      queue_csr(COEFF_1_INDEX, 32'sd1);
      for (j = FIRST_STRAY_INDEX; j <= LAST_CSR_INDEX; j++)
         queue_csr(j, $urandom() | 32'h1);
      queue_sample(Q_HALF);
      queue_sample(-Q_HALF);
      queue_sample(Q_HALF - 1);
      queue_sample(-Q_HALF - 1);

      // full-scale coefficients saturate both chains
      queue_all_coeffs(DATA_MAX);
      queue_sample(DATA_MAX);
      queue_sample(DATA_MIN);
      queue_sample(-32'sd1);
      queue_all_coeffs(DATA_MIN);
      queue_sample(DATA_MAX);
      queue_sample(32'sd1);
      queue_sample('0);

      // k*coeff_k beyond 32 bits, pulled back into range by the product term
      queue_all_coeffs('0);
      queue_csr(NUM_COEFFS - 1, 32'sh1000_0000);
      queue_csr(NUM_COEFFS - 2, DATA_MAX);
      queue_sample(-32'sh0006_DB6D);
      queue_sample('0);

      // random phases, each with a fresh coefficient set
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         mix    = coeff_mix_type'(phase % 5);
         degree = $urandom_range(1, NUM_COEFFS - 1);
         rot    = $urandom_range(0, NUM_REGS - 1);
         for (j = 0; j < NUM_REGS; j++)
            queue_csr((j + rot) % NUM_REGS, pick_coeff(mix, (j + rot) % NUM_REGS, degree));
         if ($urandom_range(0, 2) == 0)
            queue_csr($urandom_range(FIRST_STRAY_INDEX, LAST_CSR_INDEX), $urandom());
         for (j = 0; j < RANDOM_PER_PHASE; j++)
            queue_sample(pick_x());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (samples_accepted < samples_queued || predicted_evals.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results over %0d coefficient writes and %0d unmapped writes",
               results_checked, coeff_writes, stray_writes);
      $display("Saturation flagged on %0d values and %0d slopes; %0d failures",
               value_sat_seen, slope_sat_seen, fail_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
